/* hdl/point_in_capsule_test_top_assert.svh */
// assertion macros for the capsule containment test
`ifndef POINT_IN_CAPSULE_TEST_TOP_ASSERT_SVH
`define POINT_IN_CAPSULE_TEST_TOP_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define PICT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("point_in_capsule_test: assertion failed");

// next-cycle implication
`define PICT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("point_in_capsule_test: assertion failed");

`endif

/* hdl/pict_pkg.sv */
// shared constants and types for the capsule containment test
package pict_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CFG_INDEX_W     = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_END_A_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_A_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_A_Z  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_B_X  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_B_Y  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_B_Z  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS   = 3'd6;

    typedef enum logic [1:0] {
        REGION_OUTSIDE = 2'd0,
        REGION_CAP_A   = 2'd1,
        REGION_CAP_B   = 2'd2,
        REGION_BODY    = 2'd3
    } region_t;

    localparam int NUM_STAGES = 7;

endpackage

/* hdl/point_in_capsule_test_top.sv */
// capsule containment test: seven-stage pipeline, one query point per clock while the receiver keeps up
//
// s_ channel carries one query point per transaction (x, y, z, signed fixed point).
// m_ channel returns one result per query: inside flag and matched region
// (0 outside, 1 cap round end a, 2 cap round end b, 3 cylinder body).
// the capsule (end a, end b, radius) sits in registers written through the
// cfg_we / cfg_index / cfg_wdata port; write them only with the pipeline empty.
// m_tvalid is the valid bit of the seventh stage, so a result comes only after its
// query has passed every register stage. throughput is one query per cycle while
// the receiver keeps up; the seven register stages each hold one query, and the exact
// radial test splits its two wide products into half-width partial products (four for
// the left side, three for the square), so no stage holds more than one multiplier level.
// every stage has a valid bit; a stage loads whenever it is empty or its
// successor moves, so bubbles close up and s_tready stays high until all
// seven stages are full behind a stalled receiver. nothing is lost or repeated.
// reset (aresetn low, synchronous) empties the pipeline and clears the
// capsule registers to zero.
`include "point_in_capsule_test_top_assert.svh"

module point_in_capsule_test_top #(
    parameter int COORD_WIDTH = pict_pkg::COORD_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // configuration writes
    input  logic                                     cfg_we,
    input  logic [pict_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [COORD_WIDTH-1:0]                   cfg_wdata,
    // query points
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // query_x, query_y, query_z, zero fill
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    // results
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // inside_res, region[1:0], zero fill
    output logic [7:0]                               m_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;          // coordinate difference
    localparam int SW  = 2 * W + 2;      // squares and their sums
    localparam int H   = SW / 2;         // half word for split products
    localparam int PW  = 2 * SW;         // full radial products
    localparam int NS  = pict_pkg::NUM_STAGES;

    // capsule registers
    logic signed [W-1:0] end_a_reg [3];
    logic signed [W-1:0] end_b_reg [3];
    logic [W-2:0]        radius_reg;
    logic [2*W-3:0]      r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                end_a_reg[i] <= '0;
                end_b_reg[i] <= '0;
            end
            radius_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pict_pkg::CFG_END_A_X: end_a_reg[0] <= cfg_wdata;
                pict_pkg::CFG_END_A_Y: end_a_reg[1] <= cfg_wdata;
                pict_pkg::CFG_END_A_Z: end_a_reg[2] <= cfg_wdata;
                pict_pkg::CFG_END_B_X: end_b_reg[0] <= cfg_wdata;
                pict_pkg::CFG_END_B_Y: end_b_reg[1] <= cfg_wdata;
                pict_pkg::CFG_END_B_Z: end_b_reg[2] <= cfg_wdata;
                pict_pkg::CFG_RADIUS:  radius_reg   <= cfg_wdata[W-2:0];
                default: ;
            endcase
        end
    end

    // squared radius follows the radius register in the next cycle
    always_ff @(posedge aclk) begin
        r2_reg <= radius_reg * radius_reg;
    end

    // pipeline flow control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] rdy;

    always_comb begin
        rdy[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_tready = rdy[0];

    // stage 1: differences u = q - a, w = q - b, v = b - a
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] u_next [3];
    logic signed [DW-1:0] w_next [3];
    logic signed [DW-1:0] v_next [3];

    always_comb begin
        logic [W-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = s_tdata[i*W +: W];
            u_next[i] = {q[W-1], q} - {end_a_reg[i][W-1], end_a_reg[i]};
            w_next[i] = {q[W-1], q} - {end_b_reg[i][W-1], end_b_reg[i]};
            v_next[i] = {end_b_reg[i][W-1], end_b_reg[i]}
                      - {end_a_reg[i][W-1], end_a_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= u_next[i];
                w_reg[i] <= w_next[i];
                v_reg[i] <= v_next[i];
            end
        end
    end

    // stage 2: per-axis squares and dot product terms
    logic [SW-1:0]        uu_sq_reg [3];
    logic [SW-1:0]        ww_sq_reg [3];
    logic [SW-1:0]        ll_sq_reg [3];
    logic signed [SW-1:0] dp_reg    [3];

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                uu_sq_reg[i] <= SW'(u_reg[i] * u_reg[i]);
                ww_sq_reg[i] <= SW'(w_reg[i] * w_reg[i]);
                ll_sq_reg[i] <= SW'(v_reg[i] * v_reg[i]);
                dp_reg[i]    <= u_reg[i] * v_reg[i];
            end
        end
    end

    // stage 3: sums over the three axes
    logic [SW-1:0]        uu_reg;
    logic [SW-1:0]        ww_reg;
    logic [SW-1:0]        l2_reg;
    logic signed [SW:0]   d_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            uu_reg <= uu_sq_reg[0] + uu_sq_reg[1] + uu_sq_reg[2];
            ww_reg <= ww_sq_reg[0] + ww_sq_reg[1] + ww_sq_reg[2];
            l2_reg <= ll_sq_reg[0] + ll_sq_reg[1] + ll_sq_reg[2];
            d_reg  <= {dp_reg[0][SW-1], dp_reg[0]} + {dp_reg[1][SW-1], dp_reg[1]}
                    + {dp_reg[2][SW-1], dp_reg[2]};
        end
    end

    // stage 4: cap tests, projection window, radial operands
    pict_pkg::region_t region4_reg;
    pict_pkg::region_t region4_next;
    logic [SW-1:0]     e4_reg;
    logic [SW-1:0]     dm4_reg;
    logic [SW-1:0]     l4_reg;
    logic [SW-1:0]     r2_wide;
    logic              body_window;

    assign r2_wide     = SW'(r2_reg);
    assign body_window = (l2_reg != '0) && !d_reg[SW] && (d_reg[SW-1:0] <= l2_reg);

    always_comb begin
        if (uu_reg <= r2_wide) begin
            region4_next = pict_pkg::REGION_CAP_A;
        end else if (ww_reg <= r2_wide) begin
            region4_next = pict_pkg::REGION_CAP_B;
        end else if (body_window) begin
            region4_next = pict_pkg::REGION_BODY;
        end else begin
            region4_next = pict_pkg::REGION_OUTSIDE;
        end
    end

    // body test becomes (uu - r2) * l2 <= d * d; uu > r2 whenever it matters
    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            region4_reg <= region4_next;
            e4_reg      <= uu_reg - r2_wide;
            dm4_reg     <= d_reg[SW-1:0];
            l4_reg      <= l2_reg;
        end
    end

    // stage 5: half-width partial products
    pict_pkg::region_t region5_reg;
    logic [SW-1:0]     el_ll_reg;
    logic [SW-1:0]     el_lh_reg;
    logic [SW-1:0]     eh_ll_reg;
    logic [SW-1:0]     eh_lh_reg;
    logic [SW-1:0]     dd_ll_reg;
    logic [SW-1:0]     dd_lh_reg;
    logic [SW-1:0]     dd_hh_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            region5_reg <= region4_reg;
            el_ll_reg   <= e4_reg[H-1:0]  * l4_reg[H-1:0];
            el_lh_reg   <= e4_reg[H-1:0]  * l4_reg[SW-1:H];
            eh_ll_reg   <= e4_reg[SW-1:H] * l4_reg[H-1:0];
            eh_lh_reg   <= e4_reg[SW-1:H] * l4_reg[SW-1:H];
            dd_ll_reg   <= dm4_reg[H-1:0]  * dm4_reg[H-1:0];
            dd_lh_reg   <= dm4_reg[H-1:0]  * dm4_reg[SW-1:H];
            dd_hh_reg   <= dm4_reg[SW-1:H] * dm4_reg[SW-1:H];
        end
    end

    // stage 6: assemble full products
    pict_pkg::region_t region6_reg;
    logic [PW-1:0]     lhs6_reg;
    logic [PW-1:0]     rhs6_reg;
    logic [SW:0]       e_mid;

    assign e_mid = {1'b0, el_lh_reg} + {1'b0, eh_ll_reg};

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            region6_reg <= region5_reg;
            lhs6_reg    <= {eh_lh_reg, el_ll_reg} + (PW'(e_mid) << H);
            rhs6_reg    <= {dd_hh_reg, dd_ll_reg} + (PW'({dd_lh_reg, 1'b0}) << H);
        end
    end

    // stage 7: radial compare, output register
    pict_pkg::region_t region7_reg;
    pict_pkg::region_t region7_next;

    always_comb begin
        region7_next = region6_reg;
        if (region6_reg == pict_pkg::REGION_BODY && lhs6_reg > rhs6_reg) begin
            region7_next = pict_pkg::REGION_OUTSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            region7_reg <= region7_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {5'b0, region7_reg, (region7_reg != pict_pkg::REGION_OUTSIDE)};

    // checks
    `PICT_ASSERT_IMP(a_inside_matches_region, aclk, aresetn, m_tvalid,
        m_tdata[0] == (m_tdata[2:1] != pict_pkg::REGION_OUTSIDE))
    `PICT_ASSERT_IMP(a_backpressure_only_when_full, aclk, aresetn, !s_tready,
        (&vld_reg) && !m_tready)
    `PICT_ASSERT_NXT(a_cap_region_kept, aclk, aresetn,
        vld_reg[3] && rdy[4] && region4_reg == pict_pkg::REGION_CAP_A,
        region5_reg == pict_pkg::REGION_CAP_A)

endmodule

/* bench/point_in_capsule_test_top_tb.sv */
// testbench for the capsule containment test: directed and random queries against a predictor
`timescale 1ns / 1ps

module point_in_capsule_test_top_tb;

    localparam int CW = pict_pkg::COORD_WIDTH_DEF;
    localparam int SW = ((3 * CW + 7) / 8) * 8;
    localparam logic [pict_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct {
        logic [CW-1:0]     qx;
        logic [CW-1:0]     qy;
        logic [CW-1:0]     qz;
        pict_pkg::region_t region;
    } pending_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [pict_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CW-1:0]                    cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [SW-1:0]                    s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [7:0]                       m_tdata;

    // capsule as the block should hold it
    logic [CW-1:0] end_a [3];
    logic [CW-1:0] end_b [3];
    logic [CW-2:0] radius;

    pending_t awaited_results[$];
    pending_t want;
    int       mismatch_count = 0;
    int       stall_left = 0;
    bit       idling_on = 1'b1;

    point_in_capsule_test_top #(.COORD_WIDTH(CW)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

    // exact containment decision, projection and radial test scaled by the squared axis length
    function automatic pict_pkg::region_t capsule_region(input logic [CW-1:0] qx, qy, qz);
        logic [CW-1:0]       q [3];
        logic signed [127:0] ui, vi, wi, uu, ww, l2, dp, r2;
        int                  i;
        q[0] = qx;
        q[1] = qy;
        q[2] = qz;
        uu = 0;
        ww = 0;
        l2 = 0;
        dp = 0;
        for (i = 0; i < 3; i++) begin
            ui = $signed(q[i]) - $signed(end_a[i]);
            vi = $signed(end_b[i]) - $signed(end_a[i]);
            wi = $signed(q[i]) - $signed(end_b[i]);
            uu = uu + ui * ui;
            ww = ww + wi * wi;
            l2 = l2 + vi * vi;
            dp = dp + ui * vi;
        end
        r2 = $signed({105'd0, radius});
        r2 = r2 * r2;
        if (uu <= r2)
            return pict_pkg::REGION_CAP_A;
        if (ww <= r2)
            return pict_pkg::REGION_CAP_B;
        if (l2 != 0 && dp >= 0 && dp <= l2 && uu * l2 <= r2 * l2 + dp * dp)
            return pict_pkg::REGION_BODY;
        return pict_pkg::REGION_OUTSIDE;
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input pending_t p);
        $display("mismatch at %0t: %s, query %h %h %h, result %h, expected region %0d",
                 $time, what, p.qx, p.qy, p.qz, m_tdata, p.region);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [pict_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [CW-1:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
        case (idx)
            pict_pkg::CFG_END_A_X: end_a[0] = value;
            pict_pkg::CFG_END_A_Y: end_a[1] = value;
            pict_pkg::CFG_END_A_Z: end_a[2] = value;
            pict_pkg::CFG_END_B_X: end_b[0] = value;
            pict_pkg::CFG_END_B_Y: end_b[1] = value;
            pict_pkg::CFG_END_B_Z: end_b[2] = value;
            pict_pkg::CFG_RADIUS:  radius = value[CW-2:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_capsule(input logic [CW-1:0] ax, ay, az, bx, by, bz, rad_word);
        write_reg(pict_pkg::CFG_END_A_X, ax);
        write_reg(pict_pkg::CFG_END_A_Y, ay);
        write_reg(pict_pkg::CFG_END_A_Z, az);
        write_reg(pict_pkg::CFG_END_B_X, bx);
        write_reg(pict_pkg::CFG_END_B_Y, by);
        write_reg(pict_pkg::CFG_END_B_Z, bz);
        write_reg(pict_pkg::CFG_RADIUS, rad_word);
    endtask

    // one query transaction; the expectation is taken at the accepting edge
    task automatic send_query(input logic [CW-1:0] qx, qy, qz);
        int gap;
        gap = (idling_on && $urandom_range(0, 1)) ? pick_len() : 0;
        @(negedge aclk);
        repeat (gap) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = SW'({qz, qy, qx});
        do @(posedge aclk); while (!s_tready);
        awaited_results.push_back('{qx: qx, qy: qy, qz: qz, region: capsule_region(qx, qy, qz)});
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // receiver side: random stalls, mostly short
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (idling_on && $urandom_range(0, 99) < 20) begin
            m_tready = 1'b0;
            stall_left = pick_len() - 1;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                want = '{qx: '0, qy: '0, qz: '0, region: pict_pkg::REGION_OUTSIDE};
                report_mismatch("result with no query pending", want);
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[0] !== (want.region != pict_pkg::REGION_OUTSIDE))
                    report_mismatch("inside flag", want);
                if (m_tdata[2:1] !== want.region)
                    report_mismatch("region", want);
                if (m_tdata[7:3] !== 5'd0)
                    report_mismatch("fill bits", want);
            end
        end
    end

    // registers all zero: a point capsule at the origin
    task automatic test_reset_state();
        end_a = '{default: '0};
        end_b = '{default: '0};
        radius = '0;
        send_query('0, '0, '0);
        send_query(24'd1, '0, '0);
        send_query(COORD_MIN, COORD_MAX, COORD_MIN);
        wait_idle();
    endtask

    // points exactly on and just off each surface, no idling
    task automatic test_surface();
        idling_on = 1'b0;
        set_capsule('0, '0, '0, 24'd32768, '0, '0, 24'd4096);
        send_query(-24'sd4096, '0, '0);
        send_query(-24'sd4097, '0, '0);
        send_query(24'd36864, '0, '0);
        send_query(24'd36865, '0, '0);
        send_query(24'd16384, 24'd4096, '0);
        send_query(24'd16384, 24'd4097, '0);
        send_query(24'd16384, '0, -24'sd4096);
        send_query('0, 24'd4097, '0);
        send_query(24'd32768, -24'sd4097, '0);
        wait_idle();
        idling_on = 1'b1;
    endtask

    // zero radius: only the segment itself is inside
    task automatic test_zero_radius();
        set_capsule(-24'sd100, 24'd200, -24'sd300, 24'd100, -24'sd200, 24'd300, '0);
        send_query('0, '0, '0);
        send_query(24'd1, '0, '0);
        send_query(-24'sd100, 24'd200, -24'sd300);
        send_query(24'd100, -24'sd200, 24'd300);
        send_query(24'd50, -24'sd100, 24'd150);
        wait_idle();
    endtask

    // both ends equal: first cap wins, body never matches
    task automatic test_degenerate_axis();
        set_capsule(24'd1000, -24'sd1000, 24'd500, 24'd1000, -24'sd1000, 24'd500, 24'd50);
        send_query(24'd1000, -24'sd1000, 24'd550);
        send_query(24'd1000, -24'sd1000, 24'd551);
        wait_idle();
    endtask

    // full-range ends and radius; top radius bit and the unused index must be ignored
    task automatic test_extremes();
        set_capsule(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, '1);
        write_reg(CFG_UNUSED, '1);
        send_query(COORD_MIN, COORD_MIN, COORD_MIN);
        send_query(COORD_MAX, COORD_MAX, COORD_MAX);
        send_query('0, '0, '0);
        send_query(COORD_MAX, COORD_MIN, '0);
        send_query(COORD_MIN, COORD_MAX, COORD_MAX);
        wait_idle();
        set_capsule(COORD_MAX, '0, COORD_MIN, COORD_MIN, '0, COORD_MAX, 24'd1);
        send_query('0, '0, '0);
        send_query(COORD_MAX, COORD_MAX, COORD_MIN);
        wait_idle();
    endtask

    // random capsules at random scales, queries mostly scattered round the axis
    task automatic test_random_capsules(input int n_capsules, input int per_capsule);
        longint scale, off_span, t;
        longint ea [3];
        longint eb [3];
        longint pt [3];
        logic [CW-1:0] rad_word;
        int c, n, i;
        for (c = 0; c < n_capsules; c++) begin
            idling_on = (c != 2);
            if (c == 0) begin
                for (i = 0; i < 3; i++) begin
                    ea[i] = longint'($urandom());
                    eb[i] = longint'($urandom());
                end
                rad_word = CW'($urandom());
            end else begin
                scale = longint'(1) << $urandom_range(6, 22);
                for (i = 0; i < 3; i++) begin
                    ea[i] = longint'($urandom_range(0, 32'(2 * scale))) - scale;
                    eb[i] = ea[i] + longint'($urandom_range(0, 32'(2 * scale))) - scale;
                end
                rad_word = ($urandom_range(0, 9) == 0) ? '0
                                                       : CW'($urandom_range(0, 32'(scale)));
                rad_word[CW-1] = 1'($urandom_range(0, 1));
            end
            set_capsule(CW'(ea[0]), CW'(ea[1]), CW'(ea[2]),
                        CW'(eb[0]), CW'(eb[1]), CW'(eb[2]), rad_word);
            off_span = longint'(radius) * 3 / 2 + 2;
            for (n = 0; n < per_capsule; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_query(CW'($urandom()), CW'($urandom()), CW'($urandom()));
                end else begin
                    t = longint'($urandom_range(0, 20)) - 2;
                    for (i = 0; i < 3; i++)
                        pt[i] = ea[i] + (eb[i] - ea[i]) * t / 16
                                + longint'($urandom_range(0, 32'(2 * off_span))) - off_span;
                    send_query(CW'(pt[0]), CW'(pt[1]), CW'(pt[2]));
                end
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_state();
        test_surface();
        test_zero_radius();
        test_degenerate_axis();
        test_extremes();
        test_random_capsules(9, 48);
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
